/* rtl/gh_pkg.sv */
// Shared types and constants for the grid height interpolator.
package gh_pkg;

    localparam int GH_GRID_ROWS   = 5;
    localparam int GH_GRID_COLS   = 5;
    localparam int GH_ADDR_W      = 8;   // holds row*cols+col for grids up to 16x16
    localparam int GH_IDX_W       = 4;   // holds a row or column index up to 15
    localparam int GH_QUEUE_DEPTH = 4;
    localparam int GH_OUT_DEPTH   = 8;

    localparam int GH_H_W    = 24;
    localparam int GH_POS_W  = 24;
    localparam int GH_INV_W  = 24;
    localparam int GH_FRAC_W = 17;

    localparam logic [GH_INV_W-1:0] GH_INV_PITCH_RST = 24'd83886;

    localparam logic signed [31:0] GH_Z_MAX = 32'sd8388607;
    localparam logic signed [31:0] GH_Z_MIN = -32'sd8388608;

    localparam logic GH_OP_WRITE = 1'b0;
    localparam logic GH_OP_QUERY = 1'b1;

    localparam logic GH_REG_INV_X = 1'b0;
    localparam logic GH_REG_INV_Y = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic                         is_query;
        logic                         oor;
        logic [GH_ADDR_W-1:0]         addr00;   // write address for a write
        logic [GH_ADDR_W-1:0]         addr10;
        logic [GH_ADDR_W-1:0]         addr01;
        logic [GH_ADDR_W-1:0]         addr11;
        logic signed [GH_FRAC_W-1:0]  fx;
        logic signed [GH_FRAC_W-1:0]  fy;
        logic signed [GH_H_W-1:0]     height;
    } gh_cmd_t;

    typedef struct packed {
        logic                      oor;
        logic signed [GH_H_W-1:0]  z;
    } gh_res_t;

endpackage

/* rtl/grid_height_bilinear_interp.sv */
// Grid height bilinear interpolator: config registers, front, queue and back end.
// Throughput: one input word per cycle, writes and queries alike, while the queue has room.
// A query passes the front multiply, queue, grid read and five interpolation stages;
// writes produce no result.
// Reset: synchronous, active low; clears the grid to zero at once (per-entry written flags)
// and sets both reciprocal pitches to 83886. No clearing pass is needed.
module grid_height_bilinear_interp #(
    parameter int GRID_ROWS = gh_pkg::GH_GRID_ROWS,
    parameter int GRID_COLS = gh_pkg::GH_GRID_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: grid_row[2:0], grid_col[5:3], height_value[29:6], x_pos[53:30],
    //          y_pos[77:54], zero[79:78]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        s_tuser,   // op
    // m_tdata: z_offset[23:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser,   // out_of_range
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = gh_pkg::GH_INV_W;

    logic [IW-1:0]   inv_x_reg, inv_y_reg;
    logic            cfg_wr;
    logic            f_valid, f_ready;
    gh_pkg::gh_cmd_t f_cmd;
    logic            q_valid, q_ready;
    gh_pkg::gh_cmd_t q_cmd;
    gh_pkg::gh_res_t res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_x_reg <= gh_pkg::GH_INV_PITCH_RST;
            inv_y_reg <= gh_pkg::GH_INV_PITCH_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                gh_pkg::GH_REG_INV_X: inv_x_reg <= pwdata[IW-1:0];
                gh_pkg::GH_REG_INV_Y: inv_y_reg <= pwdata[IW-1:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == gh_pkg::GH_REG_INV_Y) ? {8'h00, inv_y_reg}
                                                       : {8'h00, inv_x_reg};

    gh_front #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .inv_pitch_x (inv_x_reg),
        .inv_pitch_y (inv_y_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_grid_row (s_tdata[2:0]),
        .in_grid_col (s_tdata[5:3]),
        .in_height   ($signed(s_tdata[29:6])),
        .in_x_pos    ($signed(s_tdata[53:30])),
        .in_y_pos    ($signed(s_tdata[77:54])),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd         (f_cmd)
    );

    gh_fifo #(
        .ITEM_T (gh_pkg::gh_cmd_t),
        .DEPTH  (gh_pkg::GH_QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_cmd),
        .count     ()
    );

    gh_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = res.z;
    assign m_tuser = res.oor;

endmodule

/* rtl/gh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gh_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 25
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/gh_fifo.sv */
// Small synchronous FIFO with valid/ready on both sides and a fill count.
module gh_fifo #(
    parameter type ITEM_T = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ITEM_T                      in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ITEM_T                      out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    ITEM_T         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/gh_front.sv */
// Front end: accepts input words, splits cell index and fraction, forms grid addresses.
module gh_front #(
    parameter int GRID_ROWS = gh_pkg::GH_GRID_ROWS,
    parameter int GRID_COLS = gh_pkg::GH_GRID_COLS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [gh_pkg::GH_INV_W-1:0]       inv_pitch_x,
    input  logic [gh_pkg::GH_INV_W-1:0]       inv_pitch_y,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_op,
    input  logic [2:0]                        in_grid_row,
    input  logic [2:0]                        in_grid_col,
    input  logic signed [gh_pkg::GH_H_W-1:0]  in_height,
    input  logic signed [gh_pkg::GH_POS_W-1:0] in_x_pos,
    input  logic signed [gh_pkg::GH_POS_W-1:0] in_y_pos,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output gh_pkg::gh_cmd_t                   cmd
);

    localparam int IW = gh_pkg::GH_IDX_W;
    localparam int AW = gh_pkg::GH_ADDR_W;
    localparam int FW = gh_pkg::GH_FRAC_W;

    typedef struct packed {
        logic [IW-1:0]         idx;
        logic signed [FW-1:0]  frac;
        logic                  oor;
    } split_t;

    // index truncates toward zero; fraction keeps the sign of the product
    function automatic split_t split_coord(input logic signed [47:0] p,
                                           input logic [15:0] last);
        logic [47:0] mag;
        logic [15:0] im;
        logic [15:0] fm;
        split_t      r;
        mag    = p[47] ? 48'(-p) : 48'(p);
        im     = mag[47:32];
        fm     = mag[31:16];
        r.oor  = (im > last) || (p[47] && (im != 16'd0));
        r.idx  = im[IW-1:0];
        r.frac = p[47] ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
        return r;
    endfunction

    logic                               f1_vld_reg;
    logic                               op_reg;
    logic [2:0]                         row_reg;
    logic [2:0]                         col_reg;
    logic signed [gh_pkg::GH_H_W-1:0]   height_reg;
    logic signed [47:0]                 px_reg, px_next;
    logic signed [47:0]                 py_reg, py_next;

    split_t        sx, sy;
    logic [IW-1:0] x2, y2;
    logic          wr_legal;
    logic          keep;
    logic          f_adv;

    // full 48-bit signed product: both operands are signed and extend to the target width
    assign px_next = $signed(in_x_pos) * $signed({1'b0, inv_pitch_x});
    assign py_next = $signed(in_y_pos) * $signed({1'b0, inv_pitch_y});

    always_comb begin
        sx = split_coord(px_reg, 16'(GRID_ROWS-1));
        sy = split_coord(py_reg, 16'(GRID_COLS-1));
        // last row or column reuses the same grid point
        x2 = (sx.idx == IW'(GRID_ROWS-1)) ? sx.idx : sx.idx + 1'b1;
        y2 = (sy.idx == IW'(GRID_COLS-1)) ? sy.idx : sy.idx + 1'b1;
        wr_legal = ({2'b00, row_reg} < 5'(GRID_ROWS)) && ({2'b00, col_reg} < 5'(GRID_COLS));

        cmd = '0;
        if (op_reg == gh_pkg::GH_OP_QUERY) begin
            cmd.is_query = 1'b1;
            cmd.oor      = sx.oor || sy.oor;
            cmd.addr00   = AW'(sx.idx) * AW'(GRID_COLS) + AW'(sy.idx);
            cmd.addr10   = AW'(x2) * AW'(GRID_COLS) + AW'(sy.idx);
            cmd.addr01   = AW'(sx.idx) * AW'(GRID_COLS) + AW'(y2);
            cmd.addr11   = AW'(x2) * AW'(GRID_COLS) + AW'(y2);
            cmd.fx       = sx.frac;
            cmd.fy       = sy.frac;
        end else begin
            cmd.is_query = 1'b0;
            cmd.addr00   = AW'(row_reg) * AW'(GRID_COLS) + AW'(col_reg);
            cmd.height   = height_reg;
        end
    end

    // writes outside the grid are dropped here
    assign keep      = (op_reg == gh_pkg::GH_OP_QUERY) || wr_legal;
    assign cmd_valid = f1_vld_reg && keep;
    assign f_adv     = !f1_vld_reg || !keep || cmd_ready;
    assign in_ready  = f_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (f_adv) begin
            f1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_adv && in_valid) begin
            op_reg     <= in_op;
            row_reg    <= in_grid_row;
            col_reg    <= in_grid_col;
            height_reg <= in_height;
            px_reg     <= px_next;
            py_reg     <= py_next;
        end
    end

endmodule

/* rtl/gh_back.sv */
// Back end: grid store, bilinear interpolation pipeline and result FIFO.
module gh_back #(
    parameter int GRID_ROWS = gh_pkg::GH_GRID_ROWS,
    parameter int GRID_COLS = gh_pkg::GH_GRID_COLS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  gh_pkg::gh_cmd_t cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output gh_pkg::gh_res_t res
);

    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int HW    = gh_pkg::GH_H_W;
    localparam int FW    = gh_pkg::GH_FRAC_W;
    localparam int OD    = gh_pkg::GH_OUT_DEPTH;
    localparam int OCW   = $clog2(OD+1);
    localparam int NS    = 6;

    logic [DEPTH-1:0] written_reg;
    logic [AW-1:0]    raddr [4];
    logic [HW-1:0]    rdata [4];
    logic             pop, pop_query, wr_en;
    logic [OCW-1:0]   out_count;
    logic [3:0]       inflight;
    logic             credit_ok;

    logic [NS:1]      vld_reg;
    logic [NS:1]      oor_reg;
    logic [3:0]       vb1_reg;
    logic signed [FW-1:0] fx1_reg;
    logic signed [FW-1:0] fy1_reg, fy2_reg, fy3_reg, fy4_reg;

    logic signed [HW-1:0] h00, h10, h01, h11;
    logic signed [41:0]   p1_reg, p1_next, p2_reg, p2_next;
    logic signed [HW-1:0] h00_2_reg, h01_2_reg;
    logic signed [41:0]   a1_3_reg, a1_next, a2_3_reg, a2_next;
    logic signed [42:0]   d4_reg, d_next;
    logic signed [41:0]   a1_4_reg, a1_5_reg, a1_6_reg;
    logic signed [39:0]   plo5_reg, plo_next;
    logic signed [37:0]   phi5_reg, phi_next;
    logic signed [61:0]   prod6_reg, prod_next;
    logic [63:0]          t_sum;
    logic signed [31:0]   r_floor;
    logic signed [HW-1:0] z_sat;
    gh_pkg::gh_res_t      res_in;

    // a query enters only when the result FIFO has room for everything in flight
    assign inflight  = 4'($countones(vld_reg));
    assign credit_ok = (5'(out_count) + 5'(inflight)) < 5'(OD);
    assign cmd_ready = credit_ok || !cmd.is_query;
    assign pop       = cmd_valid && cmd_ready;
    assign pop_query = pop && cmd.is_query;
    assign wr_en     = pop && !cmd.is_query;

    assign raddr[0] = cmd.addr00[AW-1:0];
    assign raddr[1] = cmd.addr10[AW-1:0];
    assign raddr[2] = cmd.addr01[AW-1:0];
    assign raddr[3] = cmd.addr11[AW-1:0];

    // one copy of the grid per corner so all four read in the same cycle
    for (genvar k = 0; k < 4; k++) begin : g_corner
        gh_ram #(
            .WIDTH (HW),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (wr_en),
            .waddr (cmd.addr00[AW-1:0]),
            .wdata (cmd.height),
            .raddr (raddr[k]),
            .rdata (rdata[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            vld_reg     <= '0;
        end else begin
            if (wr_en) begin
                written_reg[cmd.addr00[AW-1:0]] <= 1'b1;
            end
            vld_reg <= {vld_reg[NS-1:1], pop_query};
        end
    end

    // never-written entries read as zero
    assign h00 = vb1_reg[0] ? $signed(rdata[0]) : '0;
    assign h10 = vb1_reg[1] ? $signed(rdata[1]) : '0;
    assign h01 = vb1_reg[2] ? $signed(rdata[2]) : '0;
    assign h11 = vb1_reg[3] ? $signed(rdata[3]) : '0;

    always_comb begin
        p1_next  = fx1_reg * ($signed({h10[HW-1], h10}) - $signed({h00[HW-1], h00}));
        p2_next  = fx1_reg * ($signed({h11[HW-1], h11}) - $signed({h01[HW-1], h01}));
        a1_next  = $signed({{2{h00_2_reg[HW-1]}}, h00_2_reg, 16'h0000}) + p1_reg;
        a2_next  = $signed({{2{h01_2_reg[HW-1]}}, h01_2_reg, 16'h0000}) + p2_reg;
        d_next   = $signed({a2_3_reg[41], a2_3_reg}) - $signed({a1_3_reg[41], a1_3_reg});
        // fy * d split into low unsigned and high signed halves of d
        plo_next = fy4_reg * $signed({1'b0, d4_reg[21:0]});
        phi_next = fy4_reg * $signed(d4_reg[42:22]);
        prod_next = $signed({{2{phi5_reg[37]}}, phi5_reg, 22'd0})
                  + $signed({{22{plo5_reg[39]}}, plo5_reg});
        // round half up, then floor by 2^32
        t_sum   = {{6{a1_6_reg[41]}}, a1_6_reg, 16'h0000}
                + {{2{prod6_reg[61]}}, prod6_reg}
                + 64'h0000_0000_8000_0000;
        r_floor = $signed(t_sum[63:32]);
        if (r_floor > gh_pkg::GH_Z_MAX) begin
            z_sat = HW'(gh_pkg::GH_Z_MAX);
        end else if (r_floor < gh_pkg::GH_Z_MIN) begin
            z_sat = HW'(gh_pkg::GH_Z_MIN);
        end else begin
            z_sat = r_floor[HW-1:0];
        end
        res_in.oor = oor_reg[NS];
        res_in.z   = oor_reg[NS] ? '0 : z_sat;
    end

    always_ff @(posedge aclk) begin
        oor_reg   <= {oor_reg[NS-1:1], cmd.oor};
        vb1_reg   <= {written_reg[raddr[3]], written_reg[raddr[2]],
                      written_reg[raddr[1]], written_reg[raddr[0]]};
        fx1_reg   <= cmd.fx;
        fy1_reg   <= cmd.fy;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        h00_2_reg <= h00;
        h01_2_reg <= h01;
        fy2_reg   <= fy1_reg;
        a1_3_reg  <= a1_next;
        a2_3_reg  <= a2_next;
        fy3_reg   <= fy2_reg;
        d4_reg    <= d_next;
        a1_4_reg  <= a1_3_reg;
        fy4_reg   <= fy3_reg;
        plo5_reg  <= plo_next;
        phi5_reg  <= phi_next;
        a1_5_reg  <= a1_4_reg;
        prod6_reg <= prod_next;
        a1_6_reg  <= a1_5_reg;
    end

    gh_fifo #(
        .ITEM_T (gh_pkg::gh_res_t),
        .DEPTH  (OD)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[NS]),
        .in_ready  (),
        .in_data   (res_in),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res),
        .count     (out_count)
    );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the grid height bilinear interpolator.
module tb_top;
    import gh_pkg::*;

    localparam int CELLS          = GH_GRID_ROWS * GH_GRID_COLS;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 16;     // idle time after the last result, for trailing writes to land
    localparam int HOLD_CYCLES    = 300;
    localparam int WORDS_PER_STEP = 140;

    // Predicts the interpolated height of each query and holds it until the result arrives.
    class height_scoreboard;
        logic signed [GH_H_W-1:0] grid [CELLS];
        logic [GH_INV_W-1:0]      pitch_x;
        logic [GH_INV_W-1:0]      pitch_y;
        gh_res_t                  z_due [$];
        int                       errors;

        function new();
            foreach (grid[i]) grid[i] = '0;
            pitch_x = GH_INV_PITCH_RST;
            pitch_y = GH_INV_PITCH_RST;
            errors  = 0;
        endfunction

        function void set_pitch(input logic sel, input logic [GH_INV_W-1:0] val);
            if (sel == GH_REG_INV_X) pitch_x = val;
            else pitch_y = val;
        endfunction

        // cell index truncated toward zero, 16-bit fraction carrying the sign of the product
        function void split_pos(input logic signed [GH_POS_W-1:0] pos,
                                input logic [GH_INV_W-1:0] inv,
                                output longint idx, output longint frac);
            longint          prod;
            longint unsigned mag;
            prod = longint'(pos) * longint'({1'b0, inv});
            mag  = (prod < 0) ? -prod : prod;
            idx  = longint'(mag >> 32);
            frac = longint'(mag[31:16]);
            if (prod < 0) begin
                idx  = -idx;
                frac = -frac;
            end
        endfunction

        function void note_word(input logic op, input logic [2:0] row, input logic [2:0] col,
                                input logic signed [GH_H_W-1:0] h,
                                input logic signed [GH_POS_W-1:0] x,
                                input logic signed [GH_POS_W-1:0] y);
            longint  xi, yi, fx, fy, x2, y2;
            longint  h00, h10, h01, h11, a1, a2, v, r;
            gh_res_t res;
            if (op == GH_OP_WRITE) begin
                // writes past the grid edge are dropped
                if (row < GH_GRID_ROWS && col < GH_GRID_COLS)
                    grid[row * GH_GRID_COLS + col] = h;
                return;
            end
            split_pos(x, pitch_x, xi, fx);
            split_pos(y, pitch_y, yi, fy);
            if (xi < 0 || xi > GH_GRID_ROWS - 1 || yi < 0 || yi > GH_GRID_COLS - 1) begin
                res.oor = 1'b1;
                res.z   = '0;
            end else begin
                x2  = (xi == GH_GRID_ROWS - 1) ? xi : xi + 1;
                y2  = (yi == GH_GRID_COLS - 1) ? yi : yi + 1;
                h00 = longint'(grid[xi * GH_GRID_COLS + yi]);
                h10 = longint'(grid[x2 * GH_GRID_COLS + yi]);
                h01 = longint'(grid[xi * GH_GRID_COLS + y2]);
                h11 = longint'(grid[x2 * GH_GRID_COLS + y2]);
                a1  = h00 * 65536 + fx * (h10 - h00);
                a2  = h01 * 65536 + fx * (h11 - h01);
                v   = a1 * 65536 + fy * (a2 - a1);
                r   = (v + 64'sh8000_0000) >>> 32;   // round half up, floor shift
                if (r > GH_Z_MAX) r = longint'(GH_Z_MAX);
                if (r < GH_Z_MIN) r = longint'(GH_Z_MIN);
                res.oor = 1'b0;
                res.z   = r[GH_H_W-1:0];
            end
            z_due.push_back(res);
        endfunction

        function void check_word(input logic [GH_H_W-1:0] z, input logic oor);
            gh_res_t want;
            if (z_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: z=%0d oor=%0b", $signed(z), oor);
                return;
            end
            want = z_due.pop_front();
            if (want.z !== z || want.oor !== oor) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected z=%0d oor=%0b, got z=%0d oor=%0b",
                             want.z, want.oor, $signed(z), oor);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // grid_row, grid_col, height_value, x_pos, y_pos, zero pad
    logic        s_tuser  = 1'b0; // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // z_offset
    logic        m_tuser;         // out_of_range
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    height_scoreboard sb;
    int idle_pct    = 24;
    int stall_epoch = 0;

    grid_height_bilinear_interp dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic apb_write(input logic sel, input logic [GH_INV_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {8'h00, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_pitch(sel, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(input logic op, input logic [2:0] row, input logic [2:0] col,
                             input logic signed [23:0] h, input logic signed [23:0] x,
                             input logic signed [23:0] y);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, y, x, h, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(op, row, col, h, x, y);
    endtask

    // Mostly positions inside the grid for the current pitch, some near the far
    // edge, some just below zero, the rest anywhere.
    function automatic logic [23:0] rand_pos(input logic [23:0] inv, input int n_cells);
        longint      span;
        longint      back;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (inv == 0 || pick >= 88) return 24'($urandom);
        span = (longint'(n_cells) << 32) / longint'({1'b0, inv});
        if (span > 8388607) span = 8388607;
        back = (longint'(1) << 32) / longint'({1'b0, inv});
        if (back > 8388608) back = 8388608;
        if (pick < 62) return 24'($urandom_range(0, 32'(span)));
        if (pick < 74) return 24'(span - 3 + $urandom_range(0, 6));
        return 24'(-longint'($urandom_range(0, 32'(back))));
    endfunction

    task automatic send_random_words();
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [23:0] h;
        repeat (WORDS_PER_STEP) begin
            if ($urandom_range(0, 99) < 35) begin
                if ($urandom_range(0, 99) < 85) begin
                    row = 3'($urandom_range(0, GH_GRID_ROWS - 1));
                    col = 3'($urandom_range(0, GH_GRID_COLS - 1));
                end else begin
                    row = 3'($urandom_range(0, 7));
                    col = 3'($urandom_range(0, 7));
                end
                if ($urandom_range(0, 1) != 0) h = 24'($urandom);
                else h = 24'(int'($urandom_range(0, 400000)) - 200000);
                send_word(GH_OP_WRITE, row, col, h, 24'($urandom), 24'($urandom));
            end else begin
                send_word(GH_OP_QUERY, 3'($urandom), 3'($urandom), 24'($urandom),
                          rand_pos(sb.pitch_x, GH_GRID_ROWS),
                          rand_pos(sb.pitch_y, GH_GRID_COLS));
            end
        end
    endtask

    // idle the input, let queries drain, then give trailing writes time to land
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.z_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
    end

    initial begin : result_sink
        int hold_left;
        int seen_epoch;
        hold_left  = 0;
        seen_epoch = 0;
        forever begin
            @(posedge aclk);
            if (stall_epoch != seen_epoch) begin
                seen_epoch = stall_epoch;
                hold_left  = HOLD_CYCLES;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pitch: one cell is roughly 51200 position units
        send_word(GH_OP_WRITE, 3'd0, 3'd0, 24'sd8388607, '0, '0);
        send_word(GH_OP_WRITE, 3'd4, 3'd4, 24'h800000, '0, '0);
        send_word(GH_OP_WRITE, 3'd1, 3'd0, 24'h800000, '0, '0);
        send_word(GH_OP_WRITE, 3'd0, 3'd1, 24'sd8388607, '0, '0);
        send_word(GH_OP_WRITE, 3'd4, 3'd0, 24'sd12345, '0, '0);
        send_word(GH_OP_WRITE, 3'd0, 3'd4, -24'sd777, '0, '0);
        // writes past the grid edge
        send_word(GH_OP_WRITE, 3'd5, 3'd2, 24'sd111, '0, '0);
        send_word(GH_OP_WRITE, 3'd2, 3'd7, 24'sd222, '0, '0);
        send_word(GH_OP_WRITE, 3'd7, 3'd7, 24'sd333, '0, '0);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd0, 24'sd0);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd25600, 24'sd12800);
        // just below zero: extrapolated, saturates with these corner heights
        send_word(GH_OP_QUERY, '0, '0, '0, -24'sd1000, -24'sd3000);
        send_word(GH_OP_QUERY, '0, '0, '0, -24'sd60000, 24'sd0);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd0, -24'sd60000);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd205200, 24'sd225200);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd256500, 24'sd0);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd8388607, 24'sd8388607);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'h800000, 24'h800000);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd210000, 24'sd100);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd100, 24'sd230000);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd25600, -24'sd25600);
        send_word(GH_OP_QUERY, '0, '0, '0, 24'sd102700, 24'sd162600);
        send_random_words();
        settle();

        // zero pitch pins X to the first grid row; output held off so the input backs up
        apb_write(GH_REG_INV_X, 24'd0);
        apb_write(GH_REG_INV_Y, 24'hFFFFFF);
        stall_epoch++;
        send_random_words();
        settle();

        idle_pct = 0;
        apb_write(GH_REG_INV_X, 24'hFFFFFF);
        apb_write(GH_REG_INV_Y, 24'd0);
        send_random_words();
        settle();

        idle_pct = 24;
        apb_write(GH_REG_INV_X, 24'($urandom_range(20000, 4000000)));
        apb_write(GH_REG_INV_Y, 24'($urandom_range(20000, 4000000)));
        send_random_words();
        settle();

        apb_write(GH_REG_INV_X, 24'($urandom_range(1, 40000)));
        apb_write(GH_REG_INV_Y, 24'($urandom_range(1, 40000)));
        send_random_words();
        settle();

        if (sb.errors == 0 && sb.z_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gh_pkg.sv
rtl/gh_ram.sv
rtl/gh_fifo.sv
rtl/gh_front.sv
rtl/gh_back.sv
rtl/grid_height_bilinear_interp.sv
tb/tb_top.sv
